// ===== rtl/core/irdu_pkg.sv =====
// Package for the integer rotate/divide unit: opcodes, trap codes, payload structs.
// No dependencies.
`default_nettype none
package irdu_pkg;
  localparam int unsigned XLEN = 64;
  localparam int unsigned DIV_STAGES = 64;  // one quotient bit per pipeline stage

  typedef enum logic [3:0] {
    FN_ROTL32 = 4'd0, FN_ROTR32 = 4'd1, FN_ROTL64 = 4'd2, FN_ROTR64 = 4'd3,
    FN_UDIV32 = 4'd4, FN_UREM32 = 4'd5, FN_SDIV32 = 4'd6, FN_SREM32 = 4'd7,
    FN_UDIV64 = 4'd8, FN_UREM64 = 4'd9, FN_SDIV64 = 4'd10, FN_SREM64 = 4'd11
  } func_e;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0, TRAP_DIVZERO = 2'd1, TRAP_OVERFLOW = 2'd2
  } trap_e;

  typedef struct packed {
    logic [3:0]      func;
    logic [XLEN-1:0] operand_a;
    logic [XLEN-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
    logic [1:0]      trap;
  } rsp_t;

  // Per-transaction control that rides the divider pipeline.
  typedef struct packed {
    logic            valid;
    logic            want_rem;
    logic            neg_q;
    logic            neg_r;
    logic            w32;
    logic            bypass;   // rotate, trap or unused code: result already known
    logic [XLEN-1:0] bypass_res;
    logic [1:0]      trap;
  } ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/integer_rotate_divide_unit.sv =====
// Top level of the integer rotate/divide unit: decode stage, 64-stage restoring
// divider pipeline, sign fix-up and output register. Depends on irdu_pkg.
`default_nettype none
// One transaction may start every cycle; busy is always low. Every result appears
// on rsp_o with done_o high for one cycle, after passing the decode register, the 64
// divider stages with one quotient bit each and the fix-up into the output register.
// Rotates travel the same pipeline so results leave in order.
// The receiver cannot stall the unit and needs none.
module integer_rotate_divide_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire irdu_pkg::req_t   req_i,
  output logic                  done_o,
  output irdu_pkg::rsp_t        rsp_o
);
  localparam int unsigned W = irdu_pkg::XLEN;
  localparam int unsigned N = irdu_pkg::DIV_STAGES;

  assign busy = 1'b0;

  // ---------------- decode ----------------
  irdu_pkg::ctl_t  dec_ctl;
  logic [W-1:0]    dec_a, dec_b;
  logic [3:0]      fn;
  logic [31:0]     a32, r32;
  logic [4:0]      c32;
  logic [5:0]      c64;
  logic            is32, sgn, nega, negb;
  logic [W-1:0]    ma, mb, minpat, wmask;

  always_comb begin
    fn   = req_i.func;
    a32  = req_i.operand_a[31:0];
    c32  = req_i.operand_b[4:0];
    c64  = req_i.operand_b[5:0];
    is32 = (fn == irdu_pkg::FN_UDIV32) || (fn == irdu_pkg::FN_UREM32) ||
           (fn == irdu_pkg::FN_SDIV32) || (fn == irdu_pkg::FN_SREM32);
    sgn  = (fn == irdu_pkg::FN_SDIV32) || (fn == irdu_pkg::FN_SREM32) ||
           (fn == irdu_pkg::FN_SDIV64) || (fn == irdu_pkg::FN_SREM64);
    wmask  = is32 ? {{(W-32){1'b0}}, 32'hFFFF_FFFF} : '1;
    minpat = is32 ? {{(W-32){1'b0}}, 32'h8000_0000} : {1'b1, {(W-1){1'b0}}};
    ma = req_i.operand_a & wmask;
    mb = req_i.operand_b & wmask;
    nega = sgn && ((ma & minpat) != '0);
    negb = sgn && ((mb & minpat) != '0);
    dec_a = nega ? ((~ma + 1'b1) & wmask) : ma;
    dec_b = negb ? ((~mb + 1'b1) & wmask) : mb;
    r32 = '0;
    dec_ctl = '0;
    dec_ctl.valid    = start;
    dec_ctl.want_rem = fn[0];
    dec_ctl.neg_q    = nega ^ negb;
    dec_ctl.neg_r    = nega;
    dec_ctl.w32      = is32;
    dec_ctl.trap     = irdu_pkg::TRAP_NONE;
    unique case (fn)
      irdu_pkg::FN_ROTL32: begin
        r32 = (a32 << c32) | (a32 >> (6'd32 - {1'b0, c32}));
        dec_ctl.bypass = 1'b1;
        dec_ctl.bypass_res = {{(W-32){1'b0}}, r32};
      end
      irdu_pkg::FN_ROTR32: begin
        r32 = (a32 >> c32) | (a32 << (6'd32 - {1'b0, c32}));
        dec_ctl.bypass = 1'b1;
        dec_ctl.bypass_res = {{(W-32){1'b0}}, r32};
      end
      irdu_pkg::FN_ROTL64: begin
        dec_ctl.bypass = 1'b1;
        dec_ctl.bypass_res = (req_i.operand_a << c64) |
                             (req_i.operand_a >> (7'd64 - {1'b0, c64}));
      end
      irdu_pkg::FN_ROTR64: begin
        dec_ctl.bypass = 1'b1;
        dec_ctl.bypass_res = (req_i.operand_a >> c64) |
                             (req_i.operand_a << (7'd64 - {1'b0, c64}));
      end
      irdu_pkg::FN_UDIV32, irdu_pkg::FN_UREM32, irdu_pkg::FN_SDIV32,
      irdu_pkg::FN_SREM32, irdu_pkg::FN_UDIV64, irdu_pkg::FN_UREM64,
      irdu_pkg::FN_SDIV64, irdu_pkg::FN_SREM64: begin
        if (mb == '0) begin
          dec_ctl.bypass = 1'b1;
          dec_ctl.trap   = irdu_pkg::TRAP_DIVZERO;
        end else if (sgn && ma == minpat && mb == wmask) begin
          dec_ctl.bypass = 1'b1;
          dec_ctl.trap   = irdu_pkg::TRAP_OVERFLOW;
        end
      end
      default: dec_ctl.bypass = 1'b1;  // unused codes: zero, no trap
    endcase
  end

  // ---------------- divider pipeline ----------------
  // Stage k holds partial remainder, shifting dividend/quotient word and divisor.
  irdu_pkg::ctl_t ctl_q [N+1];
  logic [W-1:0]   rem_q [N+1];
  logic [W-1:0]   quo_q [N+1];
  logic [W-1:0]   dvs_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      dvs_q[0] <= '0;
    end else begin
      ctl_q[0] <= dec_ctl;
      rem_q[0] <= '0;
      quo_q[0] <= dec_a;
      dvs_q[0] <= dec_b;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    logic [W:0]   trial;
    logic [W:0]   diff;
    always_comb begin
      trial = {rem_q[k], quo_q[k][W-1]};
      diff  = trial - {1'b0, dvs_q[k]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
        dvs_q[k+1] <= '0;
        rem_q[k+1] <= '0;
        quo_q[k+1] <= '0;
      end else begin
        ctl_q[k+1] <= ctl_q[k];
        dvs_q[k+1] <= dvs_q[k];
        if (!diff[W]) begin
          rem_q[k+1] <= diff[W-1:0];
          quo_q[k+1] <= {quo_q[k][W-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= trial[W-1:0];
          quo_q[k+1] <= {quo_q[k][W-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- fix-up and output register ----------------
  irdu_pkg::rsp_t fix_d, rsp_q;
  logic           done_q;
  logic [W-1:0]   sel, wm;

  always_comb begin
    wm  = ctl_q[N].w32 ? {{(W-32){1'b0}}, 32'hFFFF_FFFF} : '1;
    if (ctl_q[N].want_rem)
      sel = ctl_q[N].neg_r ? (~rem_q[N] + 1'b1) : rem_q[N];
    else
      sel = ctl_q[N].neg_q ? (~quo_q[N] + 1'b1) : quo_q[N];
    fix_d.trap   = ctl_q[N].trap;
    fix_d.result = ctl_q[N].bypass ? ctl_q[N].bypass_res : (sel & wm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      rsp_q  <= '0;
    end else begin
      done_q <= ctl_q[N].valid;
      rsp_q  <= fix_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule
`default_nettype wire

// ===== rtl/core/irdu_checker.sv =====
// Port-level assertions for the integer rotate/divide unit, bound to the top level.
// Depends on irdu_pkg.
`default_nettype none
module irdu_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire irdu_pkg::req_t req_i,
  input wire logic           done_o,
  input wire irdu_pkg::rsp_t rsp_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 66)) else $error("unexpected done");
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##66 done_o) else $error("lost transaction");
  a_trap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.trap != irdu_pkg::TRAP_NONE) |-> rsp_o.result == '0)
    else $error("trapped result not zero");
  a_trap_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.trap == irdu_pkg::TRAP_NONE || rsp_o.trap == irdu_pkg::TRAP_DIVZERO ||
                rsp_o.trap == irdu_pkg::TRAP_OVERFLOW)) else $error("bad trap code");
endmodule

bind integer_rotate_divide_unit irdu_checker u_irdu_checker (.*);
`default_nettype wire

// ===== tb/sv/integer_rotate_divide_unit_test.sv =====
// Self-checking testbench for integer_rotate_divide_unit: rotates, divides and traps.
// Predicts each result in SV and compares in order. Depends on irdu_pkg and the RTL.
`default_nettype none
module integer_rotate_divide_unit_test;
  localparam int LATENCY = 66;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i, rst_ni, start, busy, done_o;
  irdu_pkg::req_t req_i;
  irdu_pkg::rsp_t rsp_o;

  integer_rotate_divide_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  irdu_pkg::req_t pending_reqs[$];
  irdu_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int trap_count = 0;
  bit stim_done = 0;
  bit calm = 0;

  function automatic irdu_pkg::rsp_t alu_predict(irdu_pkg::req_t r);
    irdu_pkg::rsp_t o;
    logic [63:0] a, b, wmask, minpat, ma, mb, q, rm;
    logic sgn, na, nb;
    int c;
    o.result = '0;
    o.trap = irdu_pkg::TRAP_NONE;
    a = r.operand_a;
    b = r.operand_b;
    case (r.func)
      irdu_pkg::FN_ROTL32, irdu_pkg::FN_ROTR32: begin
        c = b[4:0];
        a = {32'h0, a[31:0]};
        if (c == 0)
          o.result = a;
        else if (r.func == irdu_pkg::FN_ROTL32)
          o.result = ((a << c) | (a >> (32 - c))) & 64'hFFFFFFFF;
        else
          o.result = ((a >> c) | (a << (32 - c))) & 64'hFFFFFFFF;
      end
      irdu_pkg::FN_ROTL64, irdu_pkg::FN_ROTR64: begin
        c = b[5:0];
        if (c == 0) o.result = a;
        else if (r.func == irdu_pkg::FN_ROTL64) o.result = (a << c) | (a >> (64 - c));
        else o.result = (a >> c) | (a << (64 - c));
      end
      irdu_pkg::FN_UDIV32, irdu_pkg::FN_UREM32, irdu_pkg::FN_SDIV32, irdu_pkg::FN_SREM32,
      irdu_pkg::FN_UDIV64, irdu_pkg::FN_UREM64, irdu_pkg::FN_SDIV64, irdu_pkg::FN_SREM64:
      begin
        if (r.func <= irdu_pkg::FN_SREM32) begin
          wmask = 64'hFFFFFFFF;
          minpat = 64'h80000000;
          a = a & wmask;
          b = b & wmask;
          sgn = (r.func >= irdu_pkg::FN_SDIV32);
        end else begin
          wmask = '1;
          minpat = 64'h8000000000000000;
          sgn = (r.func >= irdu_pkg::FN_SDIV64);
        end
        if (b == 0) o.trap = irdu_pkg::TRAP_DIVZERO;
        else if (sgn && a == minpat && b == wmask) o.trap = irdu_pkg::TRAP_OVERFLOW;
        else begin
          na = sgn && ((a & minpat) != 0);
          nb = sgn && ((b & minpat) != 0);
          ma = na ? ((-a) & wmask) : a;
          mb = nb ? ((-b) & wmask) : b;
          q = ma / mb;
          rm = ma % mb;
          if (na != nb) q = -q;
          if (na) rm = -rm;
          o.result = (r.func[0] ? rm : q) & wmask;
        end
      end
      default: o.result = '0;
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000000000000000;
      3: v = 64'h80000000;
      4: v = 64'hFFFFFFFF;
      5: v = {32'h0, $urandom_range(0, 20)};
      6: v = {32'h0, $urandom};
      7: v = -{32'h0, $urandom_range(1, 20)};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_req(logic [3:0] f, logic [63:0] a, logic [63:0] b);
    irdu_pkg::req_t r;
    r.func = f;
    r.operand_a = a;
    r.operand_b = b;
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  // stimulus
  initial begin
    add_req(irdu_pkg::FN_ROTL32, 64'hFFFFFFFF_80000001, 64'd1);
    add_req(irdu_pkg::FN_ROTR32, 64'h00000000_00000001, 64'hFFFF_FFFF_FFFF_FFE1);
    add_req(irdu_pkg::FN_ROTL64, 64'h8000000000000001, 64'd0);
    add_req(irdu_pkg::FN_ROTR64, 64'h0123456789ABCDEF, 64'd127);
    add_req(irdu_pkg::FN_ROTL64, '1, 64'd63);
    add_req(irdu_pkg::FN_UDIV32, 64'hFFFFFFFF, 64'd0);
    add_req(irdu_pkg::FN_UREM64, 64'd5, 64'd0);
    add_req(irdu_pkg::FN_SDIV32, 64'h80000000, 64'hFFFFFFFF);
    add_req(irdu_pkg::FN_SREM32, 64'h80000000, 64'hFFFFFFFF);
    add_req(irdu_pkg::FN_SDIV64, 64'h8000000000000000, '1);
    add_req(irdu_pkg::FN_SREM64, 64'h8000000000000000, '1);
    add_req(irdu_pkg::FN_SDIV32, 64'hFFFFFFF9, 64'd2);
    add_req(irdu_pkg::FN_SREM32, 64'hFFFFFFF9, 64'd2);
    add_req(irdu_pkg::FN_SDIV64, 64'd7, -64'd2);
    add_req(irdu_pkg::FN_SREM64, -64'd7, -64'd2);
    add_req(irdu_pkg::FN_UDIV64, '1, 64'd1);
    add_req(irdu_pkg::FN_UREM32, 64'h1_00000007, 64'h1_00000003);
    add_req(irdu_pkg::FN_UDIV32, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_00000001);
    add_req(4'd12, '1, '1);
    add_req(4'd15, 64'd3, 64'd4);
    repeat (850) add_req(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
    stim_done = 1;
  end

  // driver: start with random gaps, calm stretch in the middle of the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    calm <= (cycle_count > 300 && cycle_count < 600);
    if (!rst_ni) begin
      start <= 0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_rsps.push_back(alu_predict(req_i));
        sent_count <= sent_count + 1;
      end
      if (!(start && busy) && pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 15))
      begin
        start <= 1;
        req_i <= pending_reqs.pop_front();
      end else if (!(start && busy)) begin
        start <= 0;
        req_i <= {4'($urandom_range(0, 15)), {$urandom, $urandom}, {$urandom, $urandom}};
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    irdu_pkg::rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected transaction result=%h trap=%0d", $time,
                 rsp_o.result, rsp_o.trap);
        errors = errors + 1;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        checked_count = checked_count + 1;
        if (exp_rsp.trap != irdu_pkg::TRAP_NONE) trap_count = trap_count + 1;
        if (rsp_o.result !== exp_rsp.result) begin
          $display("%0t: result expected %h actual %h", $time, exp_rsp.result, rsp_o.result);
          errors = errors + 1;
        end
        if (rsp_o.trap !== exp_rsp.trap) begin
          $display("%0t: trap expected %0d actual %0d", $time, exp_rsp.trap, rsp_o.trap);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) begin
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("integer_rotate_divide_unit: mismatch");
        $finish;
      end
      @(posedge clk_i);
    end
    repeat (LATENCY + 5) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results (%0d trapped).",
             sent_count, checked_count, trap_count);
    $display("Covered rotates, signed/unsigned div and rem at 32/64 bits, unused codes.");
    if (errors == 0 && expected_rsps.size() == 0)
      $display("integer_rotate_divide_unit: match");
    else
      $display("integer_rotate_divide_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
